/* rtl/pip_pkg.sv */
`timescale 1ns / 1ps

package pip_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int COORD_WIDTH  = 24;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W       = COORD_WIDTH + 1;
  localparam int PROD_W       = 2 * DIFF_W;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TEST   = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]                    operation;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
  } pip_in_t;

  typedef struct packed {
    logic             inside_res;
    logic [CNT_W-1:0] vertex_total;
    logic [1:0]       status;
  } pip_out_t;

endpackage

/* rtl/point_in_polygon_test_unit.sv */
`timescale 1ns / 1ps
// Clear, append and unknown operations: the result word is registered at the accepting
// edge and busy stays low, so one such word can be taken every cycle while no walk runs.
// Point test on n stored vertices: busy stays high for the edge walk, and the result word
// is registered at the edge where busy falls. The vertex memory delivers one vertex per
// cycle; the edge walk reads it n + 1 times.
// A test on an empty polygon answers like the other operations, with busy staying low.
// Reset (rst, synchronous) empties the polygon; vertex memory contents are not cleared.
module point_in_polygon_test_unit
  import pip_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  pip_in_t  cmd,
  output logic     busy,
  output logic     done,
  output pip_out_t result
);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
  } vtx_t;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic state;
  logic [CNT_W-1:0] count;

  vtx_t vmem [MAX_VERTICES];
  vtx_t rdata;
  logic rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic wr_en;
  logic [ADDR_W-1:0] last_addr;

  logic iss_active;
  logic iss_prime;
  logic [ADDR_W-1:0] iss_idx;
  logic rv;
  logic rprime;

  logic signed [COORD_WIDTH-1:0] px;
  logic signed [COORD_WIDTH-1:0] py;
  vtx_t prev;

  logic s2_v;
  logic s2_str;
  logic s2_dypos;
  logic signed [DIFF_W-1:0] s2_a;
  logic signed [DIFF_W-1:0] s2_dy;
  logic signed [DIFF_W-1:0] s2_c;
  logic signed [DIFF_W-1:0] s2_d;

  logic s3_v;
  logic s3_str;
  logic s3_dypos;
  logic signed [PROD_W-1:0] p1;
  logic signed [PROD_W-1:0] p2;

  logic parity;
  logic accept;
  logic full;
  logic finish;
  logic left;
  logic straddle;
  logic signed [DIFF_W-1:0] dy_now;

  assign busy      = (state == ST_WALK);
  assign accept    = start && !busy;
  assign full      = (count == CNT_W'(MAX_VERTICES));
  assign last_addr = ADDR_W'(count - CNT_W'(1));
  assign wr_en     = accept && (cmd.operation == OP_APPEND) && !full;
  assign rd_en     = (state == ST_WALK) && iss_active;
  assign rd_addr   = iss_prime ? last_addr : iss_idx;
  assign finish    = (state == ST_WALK) && !iss_active && !rv && !s2_v && !s3_v;

  // Vertex i is the word just read, vertex j the one read before it.
  assign straddle = (rdata.y >= py) != (prev.y >= py);
  assign dy_now   = DIFF_W'(prev.y) - DIFF_W'(rdata.y);
  // Exact form of px <= crossing x, with the compare direction set by the sign of dy.
  assign left     = s3_dypos ? (p1 <= p2) : (p1 >= p2);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vmem[count[ADDR_W-1:0]] <= '{x: cmd.coord_x, y: cmd.coord_y};
    end
    if (rd_en) begin
      rdata <= vmem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      done       <= 1'b0;
      iss_active <= 1'b0;
      iss_prime  <= 1'b0;
      iss_idx    <= '0;
      rv         <= 1'b0;
      rprime     <= 1'b0;
      s2_v       <= 1'b0;
      s3_v       <= 1'b0;
      parity     <= 1'b0;
    end else begin
      done   <= 1'b0;
      rv     <= rd_en;
      rprime <= iss_prime;

      if (accept) begin
        unique case (cmd.operation)
          OP_CLEAR: begin
            count  <= '0;
            done   <= 1'b1;
            result <= '{inside_res: 1'b0, vertex_total: '0, status: STAT_OK};
          end
          OP_APPEND: begin
            done <= 1'b1;
            if (full) begin
              result <= '{inside_res: 1'b0, vertex_total: count, status: STAT_FULL};
            end else begin
              count  <= count + CNT_W'(1);
              result <= '{inside_res: 1'b0, vertex_total: count + CNT_W'(1),
                          status: STAT_OK};
            end
          end
          OP_TEST: begin
            if (count == '0) begin
              done   <= 1'b1;
              result <= '{inside_res: 1'b0, vertex_total: count, status: STAT_EMPTY};
            end else begin
              state      <= ST_WALK;
              iss_active <= 1'b1;
              iss_prime  <= 1'b1;
              iss_idx    <= '0;
              parity     <= 1'b0;
              px         <= cmd.coord_x;
              py         <= cmd.coord_y;
            end
          end
          default: begin
            done   <= 1'b1;
            result <= '{inside_res: 1'b0, vertex_total: count, status: STAT_OK};
          end
        endcase
      end

      // First read fetches the last vertex, then vertices 0 to n-1 in order.
      if (rd_en) begin
        if (iss_prime) begin
          iss_prime <= 1'b0;
        end else if (iss_idx == last_addr) begin
          iss_active <= 1'b0;
        end else begin
          iss_idx <= iss_idx + ADDR_W'(1);
        end
      end

      s2_v <= rv && !rprime;
      if (rv) begin
        prev     <= rdata;
        s2_str   <= straddle;
        s2_dypos <= (dy_now > 0);
        s2_a     <= DIFF_W'(px) - DIFF_W'(rdata.x);
        s2_dy    <= dy_now;
        s2_c     <= DIFF_W'(prev.x) - DIFF_W'(rdata.x);
        s2_d     <= DIFF_W'(py) - DIFF_W'(rdata.y);
      end

      s3_v <= s2_v;
      if (s2_v) begin
        s3_str   <= s2_str;
        s3_dypos <= s2_dypos;
        p1       <= PROD_W'(s2_a) * PROD_W'(s2_dy);
        p2       <= PROD_W'(s2_c) * PROD_W'(s2_d);
      end

      if (s3_v && s3_str && left) begin
        parity <= !parity;
      end

      if (finish) begin
        state  <= ST_IDLE;
        done   <= 1'b1;
        result <= '{inside_res: parity, vertex_total: count, status: STAT_OK};
      end
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result word issued while a walk is still running");

  a_pipe_in_walk: assert property (@(posedge clk) disable iff (rst)
    (rv || s2_v || s3_v) |-> busy)
    else $error("edge pipeline active outside a walk");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond capacity");

  a_test_starts_walk: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.operation == OP_TEST && count != '0) |=> busy)
    else $error("test on a nonempty polygon did not start a walk");

  a_empty_outside: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STAT_EMPTY) |-> !result.inside_res)
    else $error("empty polygon reported inside");

  a_count_stable_walk: assert property (@(posedge clk) disable iff (rst)
    (busy && $past(busy)) |-> $stable(count))
    else $error("vertex count changed during a walk");

endmodule
